>>> rtl/core/jmsp_pkg.sv
// types, constants and helper functions shared by the manifest stream parser
package jmsp_pkg;

  typedef enum logic [2:0] {
    ROLE_NAME     = 3'd0,
    ROLE_COLON    = 3'd1,
    ROLE_VALUE    = 3'd2,
    ROLE_CONT     = 3'd3,
    ROLE_LINE_END = 3'd4,
    ROLE_BREAK    = 3'd5,
    ROLE_IGNORED  = 3'd6,
    ROLE_ERROR    = 3'd7
  } role_t;

  typedef enum logic [1:0] {
    CTX_VERSION = 2'd0,
    CTX_MAIN    = 2'd1,
    CTX_SECNAME = 2'd2,
    CTX_SECATTR = 2'd3
  } ctx_t;

  typedef enum logic [2:0] {
    PH_NAME_START  = 3'd0,
    PH_NAME        = 3'd1,
    PH_VALUE_SPACE = 3'd2,
    PH_VALUE       = 3'd3,
    PH_LINE_START  = 3'd4,
    PH_CONT        = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    OUT_RUNNING  = 2'd0,
    OUT_ACCEPTED = 2'd1,
    OUT_FAILED   = 2'd2
  } outcome_t;

  typedef struct packed {
    logic     ignore;
    ctx_t     ctx;
    phase_t   phase;
    logic     pending_cr;
    logic [4:0] kw_prog;
    logic [2:0] kw_cand;
    logic [1:0] vphase;
    logic     mc_seen;
    logic     in_mcv;
    outcome_t outcome;
  } gst_t;

  typedef struct packed {
    role_t role;
    logic  in_ind;
    logic  mcb;
  } res_t;

  localparam int KW_VERSION    = 0;
  localparam int KW_NAME       = 1;
  localparam int KW_MAIN_CLASS = 2;
  localparam int KW_COUNT      = 3;
  localparam int KW_MAX_CHARS  = 16;

  localparam logic [127:0] KW_VERSION_TEXT = "Manifest-Version";
  localparam logic [127:0] KW_NAME_TEXT    = {"Name", 96'd0};
  localparam logic [127:0] KW_MCLASS_TEXT  = {"Main-Class", 48'd0};
  localparam logic [4:0]   KW_VERSION_LEN  = 5'd16;
  localparam logic [4:0]   KW_NAME_LEN     = 5'd4;
  localparam logic [4:0]   KW_MCLASS_LEN   = 5'd10;
  localparam logic [4:0]   KW_PROG_MAX     = 5'd31;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a) || is_digit(c);
  endfunction

  function automatic logic is_headerchar(input logic [7:0] c);
    return is_alnum(c) || c == CH_DASH || c == CH_UNDER;
  endfunction

  function automatic logic [4:0] kw_len(input int k);
    logic [4:0] len;
    case (k)
      KW_VERSION:    len = KW_VERSION_LEN;
      KW_NAME:       len = KW_NAME_LEN;
      KW_MAIN_CLASS: len = KW_MCLASS_LEN;
      default:       len = 5'd0;
    endcase
    return len;
  endfunction

  // true when keyword k holds character c at position idx
  function automatic logic kw_hit(input int k, input logic [4:0] idx, input logic [7:0] c);
    logic [127:0] text;
    logic         hit;
    case (k)
      KW_VERSION:    text = KW_VERSION_TEXT;
      KW_NAME:       text = KW_NAME_TEXT;
      KW_MAIN_CLASS: text = KW_MCLASS_TEXT;
      default:       text = '0;
    endcase
    hit = 1'b0;
    for (int i = 0; i < KW_MAX_CHARS; i++) begin
      if (idx == 5'(i) && idx < kw_len(k) && text[127 - 8*i -: 8] == c) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

>>> rtl/core/jmsp_kw.sv
// keyword tracker: narrows the candidate keywords one name byte at a time
module jmsp_kw (
  input  logic [4:0]                     prog,
  input  logic [2:0]                     cand,
  input  logic                           restart,
  input  logic [7:0]                     c,
  output logic [4:0]                     prog_next,
  output logic [2:0]                     cand_next,
  output logic [jmsp_pkg::KW_COUNT-1:0]  match
);
  import jmsp_pkg::*;

  logic [4:0] base_prog;
  logic [2:0] base_cand;

  assign base_prog = restart ? 5'd0 : prog;
  assign base_cand = restart ? 3'b111 : cand;
  assign prog_next = (base_prog < KW_PROG_MAX) ? base_prog + 5'd1 : base_prog;

  always_comb begin
    for (int k = 0; k < KW_COUNT; k++) begin
      cand_next[k] = base_cand[k] && kw_hit(k, base_prog, c);
      match[k]     = cand[k] && (prog == kw_len(k));
    end
  end

endmodule

>>> rtl/core/jmsp_step.sv
// grammar step: next parser state and result for one manifest byte
module jmsp_step #(
  parameter int VERSION_WIDTH = 16
) (
  input  jmsp_pkg::gst_t             st,
  input  logic [VERSION_WIDTH-1:0]   major,
  input  logic [VERSION_WIDTH-1:0]   minor,
  input  logic [7:0]                 c,
  output jmsp_pkg::gst_t             st_next,
  output logic [VERSION_WIDTH-1:0]   major_next,
  output logic [VERSION_WIDTH-1:0]   minor_next,
  output jmsp_pkg::res_t             res
);
  import jmsp_pkg::*;

  localparam logic [VERSION_WIDTH+3:0] VMAX = {4'b0000, {VERSION_WIDTH{1'b1}}};

  function automatic logic [VERSION_WIDTH-1:0] sat10(input logic [VERSION_WIDTH-1:0] acc,
                                                     input logic [3:0] d);
    logic [VERSION_WIDTH+3:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{VERSION_WIDTH{1'b0}}, d};
    return (v > VMAX) ? VMAX[VERSION_WIDTH-1:0] : v[VERSION_WIDTH-1:0];
  endfunction

  logic [4:0]          kw_prog_fed;
  logic [2:0]          kw_cand_fed;
  logic [KW_COUNT-1:0] kw_match;
  logic                kw_restart;
  logic                kw_step;
  logic                fail_now;
  logic                sep_now;
  logic                ignore_now;
  logic                broken;
  logic                redirect;
  logic                is_eol;
  ctx_t                rctx;
  role_t               role;
  logic                mcb;
  logic [3:0]          d;

  assign kw_restart = (st.phase != PH_NAME);
  assign is_eol     = (c == CH_CR) || (c == CH_LF);
  assign d          = c[3:0];

  jmsp_kw u_kw (
    .prog      (st.kw_prog),
    .cand      (st.kw_cand),
    .restart   (kw_restart),
    .c         (c),
    .prog_next (kw_prog_fed),
    .cand_next (kw_cand_fed),
    .match     (kw_match)
  );

  always_comb begin
    st_next    = st;
    major_next = major;
    minor_next = minor;
    role       = ROLE_IGNORED;
    mcb        = 1'b0;
    fail_now   = 1'b0;
    sep_now    = 1'b0;
    ignore_now = 1'b0;
    broken     = 1'b0;
    redirect   = 1'b0;
    kw_step    = 1'b0;
    rctx       = st.ctx;
    if (st.outcome == OUT_FAILED) begin
      role = ROLE_ERROR;
    end else if (st.ignore) begin
      role = ROLE_IGNORED;
    end else if (st.pending_cr && c == CH_LF) begin
      st_next.pending_cr = 1'b0;
      role = (st.phase == PH_LINE_START) ? ROLE_LINE_END : ROLE_BREAK;
    end else if (c == CH_NUL) begin
      st_next.pending_cr = 1'b0;
      if (st.outcome == OUT_RUNNING) begin
        fail_now = 1'b1;
      end else begin
        ignore_now = 1'b1;
      end
    end else begin
      st_next.pending_cr = 1'b0;
      case (st.phase)
        PH_NAME_START: begin
          redirect = 1'b1;
        end
        PH_NAME: begin
          if (is_headerchar(c)) begin
            kw_step = 1'b1;
            role    = ROLE_NAME;
          end else if (c == CH_COLON) begin
            role          = ROLE_COLON;
            st_next.phase = PH_VALUE_SPACE;
            if (st.ctx == CTX_VERSION && !kw_match[KW_VERSION]) begin
              fail_now = 1'b1;
            end else if (st.ctx == CTX_MAIN && kw_match[KW_MAIN_CLASS] && !st.mc_seen) begin
              st_next.in_mcv = 1'b1;
            end else if (st.ctx == CTX_SECNAME && !kw_match[KW_NAME]) begin
              ignore_now = 1'b1;
            end
          end else begin
            broken = 1'b1;
          end
        end
        PH_VALUE_SPACE: begin
          if (c == CH_SPACE) begin
            role          = ROLE_VALUE;
            st_next.phase = PH_VALUE;
          end else if (st.ctx == CTX_SECATTR) begin
            redirect = 1'b1;
            rctx     = CTX_SECNAME;
          end else begin
            broken = 1'b1;
          end
        end
        PH_VALUE, PH_CONT: begin
          if (is_eol) begin
            role               = ROLE_LINE_END;
            st_next.phase      = PH_LINE_START;
            st_next.pending_cr = (c == CH_CR);
          end else begin
            role = (st.phase == PH_VALUE) ? ROLE_VALUE : ROLE_CONT;
            mcb  = st.in_mcv;
            if (st.ctx == CTX_VERSION) begin
              if (is_digit(c)) begin
                case (st.vphase)
                  2'd0: begin
                    major_next     = sat10('0, d);
                    st_next.vphase = 2'd1;
                  end
                  2'd1: major_next = sat10(major, d);
                  2'd2: begin
                    minor_next     = sat10('0, d);
                    st_next.vphase = 2'd3;
                  end
                  default: minor_next = sat10(minor, d);
                endcase
              end else if (c == CH_DOT && st.vphase == 2'd1) begin
                st_next.vphase = 2'd2;
              end else begin
                fail_now = 1'b1;
              end
            end
          end
        end
        PH_LINE_START: begin
          if (c == CH_SPACE) begin
            role          = ROLE_CONT;
            st_next.phase = PH_CONT;
          end else begin
            case (st.ctx)
              CTX_VERSION: begin
                if (st.vphase != 2'd3) begin
                  fail_now = 1'b1;
                end else begin
                  redirect = 1'b1;
                  rctx     = CTX_MAIN;
                end
              end
              CTX_MAIN: begin
                if (st.in_mcv) begin
                  st_next.mc_seen = 1'b1;
                  st_next.in_mcv  = 1'b0;
                end
                redirect = 1'b1;
                rctx     = CTX_MAIN;
              end
              default: begin
                redirect = 1'b1;
                rctx     = CTX_SECATTR;
              end
            endcase
          end
        end
        default: begin
          ignore_now = 1'b1;
        end
      endcase
      // header start at a name start, after a line end or after a missing value space in a section
      if (redirect) begin
        st_next.ctx = rctx;
        if (is_alnum(c)) begin
          kw_step       = 1'b1;
          st_next.phase = PH_NAME;
          role          = ROLE_NAME;
        end else begin
          st_next.phase = PH_NAME_START;
          broken        = 1'b1;
        end
      end
      if (broken) begin
        case (rctx)
          CTX_VERSION: fail_now   = 1'b1;
          CTX_MAIN:    sep_now    = 1'b1;
          default:     ignore_now = 1'b1;
        endcase
      end
    end
    if (sep_now) begin
      st_next.in_mcv = 1'b0;
      if (is_eol) begin
        st_next.outcome    = OUT_ACCEPTED;
        st_next.ctx        = CTX_SECNAME;
        st_next.phase      = PH_NAME_START;
        st_next.pending_cr = (c == CH_CR);
        role               = ROLE_BREAK;
      end else begin
        fail_now = 1'b1;
      end
    end
    if (fail_now) begin
      st_next.outcome = OUT_FAILED;
      st_next.in_mcv  = 1'b0;
      role            = ROLE_ERROR;
      mcb             = 1'b0;
    end
    if (ignore_now) begin
      st_next.ignore = 1'b1;
      role           = ROLE_IGNORED;
    end
    if (kw_step) begin
      st_next.kw_prog = kw_prog_fed;
      st_next.kw_cand = kw_cand_fed;
    end
    res.role   = role;
    res.mcb    = mcb;
    res.in_ind = (role <= ROLE_LINE_END) && (st_next.outcome != OUT_FAILED) &&
                 !st_next.ignore &&
                 (st_next.ctx == CTX_SECNAME || st_next.ctx == CTX_SECATTR);
  end

endmodule

>>> rtl/core/jar_manifest_stream_parser_top.sv
// manifest stream parser top level: input register, grammar step, result register
// a byte passes the input register, then the grammar step, into the result register
// throughput: one byte per cycle without output stall, limited by the single grammar step
// an empty input register takes a new byte while a result waits in the output register
// reset (rst, synchronous): grammar at the first main header name, versions zero,
// outcome running, both pipeline registers empty
module jar_manifest_stream_parser_top #(
  parameter int VERSION_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               text_byte,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [2:0]               byte_role,
  output logic                     in_individual_section,
  output logic                     main_class_byte,
  output logic                     accepted,
  output logic                     failed,
  output logic [VERSION_WIDTH-1:0] manifest_major,
  output logic [VERSION_WIDTH-1:0] manifest_minor
);
  import jmsp_pkg::*;

  logic                     in_q_valid;
  logic [7:0]               in_q_byte;
  logic                     advance;
  gst_t                     st;
  gst_t                     st_next;
  logic [VERSION_WIDTH-1:0] major;
  logic [VERSION_WIDTH-1:0] minor;
  logic [VERSION_WIDTH-1:0] major_next;
  logic [VERSION_WIDTH-1:0] minor_next;
  res_t                     res;

  assign advance  = in_q_valid && (!out_valid || !out_stall);
  assign in_stall = in_q_valid && !advance;

  jmsp_step #(
    .VERSION_WIDTH (VERSION_WIDTH)
  ) u_step (
    .st         (st),
    .major      (major),
    .minor      (minor),
    .c          (in_q_byte),
    .st_next    (st_next),
    .major_next (major_next),
    .minor_next (minor_next),
    .res        (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_q_byte <= text_byte;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.ignore     <= 1'b0;
      st.ctx        <= CTX_VERSION;
      st.phase      <= PH_NAME_START;
      st.pending_cr <= 1'b0;
      st.kw_prog    <= 5'd0;
      st.kw_cand    <= 3'b111;
      st.vphase     <= 2'd0;
      st.mc_seen    <= 1'b0;
      st.in_mcv     <= 1'b0;
      st.outcome    <= OUT_RUNNING;
      major         <= '0;
      minor         <= '0;
    end else if (advance) begin
      st    <= st_next;
      major <= major_next;
      minor <= minor_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      byte_role             <= res.role;
      in_individual_section <= res.in_ind;
      main_class_byte       <= res.mcb;
      accepted              <= (st_next.outcome == OUT_ACCEPTED);
      failed                <= (st_next.outcome == OUT_FAILED);
      manifest_major        <= major_next;
      manifest_minor        <= minor_next;
    end
  end

  a_fail_sticky: assert property (@(posedge clk) disable iff (rst)
    st.outcome == OUT_FAILED |=> st.outcome == OUT_FAILED)
    else $error("parse failure did not stay set");

  a_error_role: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((byte_role == ROLE_ERROR) == failed))
    else $error("error role and failed flag disagree");

  a_status_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(accepted && failed))
    else $error("accepted and failed both set");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while result register free");

endmodule
